// ----- sv/tgm_pkg.sv -----
// ----------------------------------------------------------------------------
// tgm_pkg
// Shared types, event codes and register reset values for the touch gesture
// to mouse event translator.
// ----------------------------------------------------------------------------
package tgm_pkg;

    // Default parameter values
    localparam int COORD_BITS_DEF = 16;
    localparam int MAX_BANDS_DEF  = 8;

    // Configuration register indexes
    localparam logic [2:0] CFG_MOVE_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_HOLD_LIMIT     = 3'd1;
    localparam logic [2:0] CFG_EDGE_X         = 3'd2;
    localparam logic [2:0] CFG_BAND_HEIGHT    = 3'd3;
    localparam logic [2:0] CFG_BAND_COUNT     = 3'd4;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // Register reset values
    localparam logic [9:0]         RST_MOVE_THRESHOLD = 10'd10;
    localparam logic [9:0]         RST_HOLD_LIMIT     = 10'd50;
    localparam logic signed [15:0] RST_EDGE_X         = -16'sd10;
    localparam logic [9:0]         RST_BAND_HEIGHT    = 10'd100;
    localparam logic [3:0]         RST_BAND_COUNT     = 4'd8;

    // Hold counter saturates here
    localparam logic [9:0] TICK_MAX = 10'd1023;

    // Event kinds
    typedef enum logic [1:0] {
        EV_MOVE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2,
        EV_MACRO   = 2'd3
    } t_evt_kind;

    // Button codes
    localparam logic [2:0] BTN_NONE  = 3'd0;
    localparam logic [2:0] BTN_LEFT  = 3'd1;
    localparam logic [2:0] BTN_RIGHT = 3'd3;
    localparam logic [2:0] BTN_UP    = 3'd4;
    localparam logic [2:0] BTN_DOWN  = 3'd5;

    // Configuration register set
    typedef struct packed {
        logic [9:0]         move_threshold;
        logic [9:0]         hold_limit;
        logic signed [15:0] edge_x;
        logic [9:0]         band_height;
        logic [3:0]         band_count;
    } t_cfg;

    // One event without its position; a move always comes last in a batch
    typedef struct packed {
        t_evt_kind  kind;
        logic [2:0] button;
        logic [2:0] macro_index;
    } t_evt;

    // Up to three events caused by one sample
    typedef struct packed {
        t_evt [2:0] slot;
        logic [1:0] cnt;
    } t_batch;

    function automatic t_evt mk_evt(t_evt_kind k, logic [2:0] b, logic [2:0] m);
        t_evt e;
        e.kind        = k;
        e.button      = b;
        e.macro_index = m;
        return e;
    endfunction

endpackage

// ----- sv/tgm_if.sv -----
// ----------------------------------------------------------------------------
// tgm_if
// Valid/ready channels: touch samples in, mouse events out, register writes.
// ----------------------------------------------------------------------------
interface tgm_touch_if #(
    parameter int COORD_BITS = tgm_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [3:0]                   touch_count;
    logic signed [COORD_BITS-1:0] touch_x;
    logic signed [COORD_BITS-1:0] touch_y;

    modport source (output valid, touch_count, touch_x, touch_y, input ready);
    modport sink   (input valid, touch_count, touch_x, touch_y, output ready);
endinterface

interface tgm_event_if #(
    parameter int COORD_BITS = tgm_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   event_kind;
    logic [2:0]                   button;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic [2:0]                   macro_index;
    logic                         last;

    modport source (output valid, event_kind, button, pos_x, pos_y, macro_index, last,
                    input ready);
    modport sink   (input valid, event_kind, button, pos_x, pos_y, macro_index, last,
                    output ready);
endinterface

interface tgm_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [tgm_pkg::CFG_IDX_BITS-1:0]   reg_index;
    logic [tgm_pkg::CFG_DATA_BITS-1:0]  wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// ----- sv/tgm_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// tgm_cfg_regs
// Configuration register file, written one register per request.
// ----------------------------------------------------------------------------
module tgm_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tgm_cfg_if.sink         i_cfg,
    output tgm_pkg::t_cfg   o_cfg
);

    tgm_pkg::t_cfg r_cfg;
    logic          wr_en;

    // Writes are always taken
    assign i_cfg.ready = 1'b1;
    assign wr_en       = i_cfg.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.move_threshold <= tgm_pkg::RST_MOVE_THRESHOLD;
            r_cfg.hold_limit     <= tgm_pkg::RST_HOLD_LIMIT;
            r_cfg.edge_x         <= tgm_pkg::RST_EDGE_X;
            r_cfg.band_height    <= tgm_pkg::RST_BAND_HEIGHT;
            r_cfg.band_count     <= tgm_pkg::RST_BAND_COUNT;
        end else if (wr_en) begin
            case (i_cfg.reg_index)
                tgm_pkg::CFG_MOVE_THRESHOLD: r_cfg.move_threshold <= i_cfg.wr_data[9:0];
                tgm_pkg::CFG_HOLD_LIMIT:     r_cfg.hold_limit     <= i_cfg.wr_data[9:0];
                tgm_pkg::CFG_EDGE_X:         r_cfg.edge_x         <= $signed(i_cfg.wr_data);
                tgm_pkg::CFG_BAND_HEIGHT:    r_cfg.band_height    <= i_cfg.wr_data[9:0];
                tgm_pkg::CFG_BAND_COUNT:     r_cfg.band_count     <= i_cfg.wr_data[3:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- sv/tgm_decide.sv -----
// ----------------------------------------------------------------------------
// tgm_decide
// Input register, gesture state and the per-sample event decision.
// ----------------------------------------------------------------------------
module tgm_decide #(
    parameter int COORD_BITS = tgm_pkg::COORD_BITS_DEF,
    parameter int MAX_BANDS  = tgm_pkg::MAX_BANDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tgm_touch_if.sink                     i_touch,
    input  tgm_pkg::t_cfg                 i_cfg,
    input  logic                          i_free,
    output logic                          o_load,
    output tgm_pkg::t_batch               o_batch,
    output logic signed [COORD_BITS-1:0]  o_pos_x,
    output logic signed [COORD_BITS-1:0]  o_pos_y
);

    localparam int EW = (COORD_BITS > 16) ? COORD_BITS : 16;
    localparam int CW = ((COORD_BITS > 15) ? COORD_BITS : 15) + 1;
    localparam int DW = (COORD_BITS + 1 > 11) ? COORD_BITS + 1 : 11;
    localparam int IW = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_MACRO  = 3'd1,
        PH_TOUCH  = 3'd2,
        PH_DRAG   = 3'd3,
        PH_HOLD   = 3'd4,
        PH_SCROLL = 3'd5
    } t_phase;

    // Input register
    logic                         r_in_valid;
    logic [3:0]                   r_cnt;
    logic signed [COORD_BITS-1:0] r_x;
    logic signed [COORD_BITS-1:0] r_y;

    // Gesture state
    t_phase                       r_phase,  n_phase;
    logic signed [COORD_BITS-1:0] r_ax,     n_ax;
    logic signed [COORD_BITS-1:0] r_ay,     n_ay;
    logic [9:0]                   r_ticks,  n_ticks;

    logic                         fire;
    logic                         in_take;
    tgm_pkg::t_batch              batch;

    // Edge and band lookup
    logic signed [EW-1:0]         x_e;
    logic signed [EW-1:0]         edge_e;
    logic                         at_edge;
    logic signed [CW-1:0]         y_c;
    logic signed [CW-1:0]         band_top [MAX_BANDS];
    logic [MAX_BANDS-1:0]         band_hit;
    logic                         band_found;
    logic [IW-1:0]                band_idx;

    // Drag test
    logic signed [DW-1:0]         dx, dy, adx, ady;
    logic                         moved;

    // Scroll step
    logic [2:0]                   sc_btn;
    tgm_pkg::t_batch              sc_batch;

    assign fire    = r_in_valid && i_free;
    assign in_take = i_touch.valid && i_touch.ready;
    assign i_touch.ready = !r_in_valid || i_free;

    // Edge test
    assign x_e     = EW'(r_x);
    assign edge_e  = EW'(i_cfg.edge_x);
    assign at_edge = x_e < edge_e;

    // Band bounds, one compare per band
    assign y_c = CW'(r_y);
    always_comb begin
        for (int i = 0; i < MAX_BANDS; i++) begin
            band_top[i] = CW'((i + 1) * int'(i_cfg.band_height));
            band_hit[i] = (i < int'(i_cfg.band_count)) && (y_c < band_top[i]);
        end
    end

    // Lowest band that matches
    always_comb begin
        band_found = 1'b0;
        band_idx   = '0;
        for (int i = MAX_BANDS - 1; i >= 0; i--) begin
            if (band_hit[i]) begin
                band_found = 1'b1;
                band_idx   = IW'(i);
            end
        end
    end

    // Distance from anchor on either axis
    assign dx    = DW'(r_x) - DW'(r_ax);
    assign dy    = DW'(r_y) - DW'(r_ay);
    assign adx   = dx[DW-1] ? -dx : dx;
    assign ady   = dy[DW-1] ? -dy : dy;
    assign moved = ($unsigned(adx) > DW'(i_cfg.move_threshold))
                || ($unsigned(ady) > DW'(i_cfg.move_threshold));

    // Scroll step events
    always_comb begin
        if (r_y < r_ay) begin
            sc_btn = tgm_pkg::BTN_DOWN;
        end else if (r_y > r_ay) begin
            sc_btn = tgm_pkg::BTN_UP;
        end else begin
            sc_btn = tgm_pkg::BTN_NONE;
        end
        sc_batch = '0;
        if (sc_btn != tgm_pkg::BTN_NONE) begin
            sc_batch.slot[0] = tgm_pkg::mk_evt(tgm_pkg::EV_PRESS, sc_btn, 3'd0);
            sc_batch.slot[1] = tgm_pkg::mk_evt(tgm_pkg::EV_RELEASE, sc_btn, 3'd0);
            sc_batch.slot[2] = tgm_pkg::mk_evt(tgm_pkg::EV_MOVE, tgm_pkg::BTN_NONE, 3'd0);
            sc_batch.cnt     = 2'd3;
        end else begin
            sc_batch.slot[0] = tgm_pkg::mk_evt(tgm_pkg::EV_MOVE, tgm_pkg::BTN_NONE, 3'd0);
            sc_batch.cnt     = 2'd1;
        end
    end

    // Event decision and next state
    always_comb begin
        n_phase = r_phase;
        n_ax    = r_ax;
        n_ay    = r_ay;
        n_ticks = r_ticks;
        batch   = '0;
        case (r_phase)
            PH_MACRO, PH_HOLD: begin
                if (r_cnt == 4'd0) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_SCROLL: begin
                if (r_cnt == 4'd0) begin
                    n_phase = PH_IDLE;
                end else begin
                    batch = sc_batch;
                    n_ax  = r_x;
                    n_ay  = r_y;
                end
            end
            PH_DRAG: begin
                if (r_cnt == 4'd0) begin
                    batch.slot[0] = tgm_pkg::mk_evt(tgm_pkg::EV_RELEASE,
                                                    tgm_pkg::BTN_LEFT, 3'd0);
                    batch.cnt     = 2'd1;
                    n_phase       = PH_IDLE;
                end else begin
                    batch.slot[0] = tgm_pkg::mk_evt(tgm_pkg::EV_MOVE,
                                                    tgm_pkg::BTN_NONE, 3'd0);
                    batch.cnt     = 2'd1;
                end
            end
            PH_TOUCH: begin
                if (r_cnt == 4'd0) begin
                    // Quick release: left click
                    batch.slot[0] = tgm_pkg::mk_evt(tgm_pkg::EV_PRESS,
                                                    tgm_pkg::BTN_LEFT, 3'd0);
                    batch.slot[1] = tgm_pkg::mk_evt(tgm_pkg::EV_RELEASE,
                                                    tgm_pkg::BTN_LEFT, 3'd0);
                    batch.cnt     = 2'd2;
                    n_phase       = PH_IDLE;
                end else if (r_cnt > 4'd1) begin
                    batch   = sc_batch;
                    n_ax    = r_x;
                    n_ay    = r_y;
                    n_phase = PH_SCROLL;
                end else begin
                    if (moved) begin
                        batch.slot[0] = tgm_pkg::mk_evt(tgm_pkg::EV_PRESS,
                                                        tgm_pkg::BTN_LEFT, 3'd0);
                        batch.slot[1] = tgm_pkg::mk_evt(tgm_pkg::EV_MOVE,
                                                        tgm_pkg::BTN_NONE, 3'd0);
                        batch.cnt     = 2'd2;
                        n_phase       = PH_DRAG;
                    end else if (r_ticks > i_cfg.hold_limit) begin
                        batch.slot[0] = tgm_pkg::mk_evt(tgm_pkg::EV_PRESS,
                                                        tgm_pkg::BTN_RIGHT, 3'd0);
                        batch.slot[1] = tgm_pkg::mk_evt(tgm_pkg::EV_RELEASE,
                                                        tgm_pkg::BTN_RIGHT, 3'd0);
                        batch.cnt     = 2'd2;
                        n_phase       = PH_HOLD;
                    end
                    if (r_ticks < tgm_pkg::TICK_MAX) begin
                        n_ticks = r_ticks + 10'd1;
                    end
                end
            end
            default: begin
                // Idle and unused codes
                n_phase = PH_IDLE;
                if (r_cnt != 4'd0) begin
                    if (at_edge) begin
                        if (band_found) begin
                            batch.slot[0] = tgm_pkg::mk_evt(tgm_pkg::EV_MACRO,
                                                            tgm_pkg::BTN_NONE,
                                                            3'(band_idx));
                            batch.cnt     = 2'd1;
                            n_phase       = PH_MACRO;
                        end
                    end else begin
                        batch.slot[0] = tgm_pkg::mk_evt(tgm_pkg::EV_MOVE,
                                                        tgm_pkg::BTN_NONE, 3'd0);
                        batch.cnt     = 2'd1;
                        n_ax          = r_x;
                        n_ay          = r_y;
                        n_ticks       = 10'd1;
                        n_phase       = (r_cnt > 4'd1) ? PH_SCROLL : PH_TOUCH;
                    end
                end
            end
        endcase
    end

    // State and input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_IDLE;
            r_ax       <= '0;
            r_ay       <= '0;
            r_ticks    <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_phase <= n_phase;
                r_ax    <= n_ax;
                r_ay    <= n_ay;
                r_ticks <= n_ticks;
            end
        end
        if (in_take) begin
            r_cnt <= i_touch.touch_count;
            r_x   <= i_touch.touch_x;
            r_y   <= i_touch.touch_y;
        end
    end

    assign o_load  = fire;
    assign o_batch = batch;
    assign o_pos_x = r_x;
    assign o_pos_y = r_y;

endmodule

// ----- sv/tgm_evt_out.sv -----
// ----------------------------------------------------------------------------
// tgm_evt_out
// Result register: holds one sample's events and hands them out in order.
// ----------------------------------------------------------------------------
module tgm_evt_out #(
    parameter int COORD_BITS = tgm_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  tgm_pkg::t_batch               i_batch,
    input  logic signed [COORD_BITS-1:0]  i_pos_x,
    input  logic signed [COORD_BITS-1:0]  i_pos_y,
    output logic                          o_free,
    tgm_event_if.source                   o_event
);

    tgm_pkg::t_evt [2:0]          r_slot;
    logic [1:0]                   r_cnt;
    logic signed [COORD_BITS-1:0] r_pos_x;
    logic signed [COORD_BITS-1:0] r_pos_y;
    logic                         pop;
    logic                         is_move;

    assign pop    = o_event.valid && o_event.ready;
    // Room for a new batch once the last held event leaves
    assign o_free = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && o_event.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_batch.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
        if (i_load) begin
            r_slot  <= i_batch.slot;
            r_pos_x <= i_pos_x;
            r_pos_y <= i_pos_y;
        end else if (pop) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

    // Head event drives the channel
    assign is_move             = r_slot[0].kind == tgm_pkg::EV_MOVE;
    assign o_event.valid       = r_cnt != 2'd0;
    assign o_event.event_kind  = r_slot[0].kind;
    assign o_event.button      = r_slot[0].button;
    assign o_event.macro_index = r_slot[0].macro_index;
    assign o_event.pos_x       = is_move ? r_pos_x : '0;
    assign o_event.pos_y       = is_move ? r_pos_y : '0;
    assign o_event.last        = r_cnt == 2'd1;

endmodule

// ----- sv/touch_gesture_to_mouse_events_top.sv -----
// Flow: a sample enters the input register on acceptance; its events are
//   loaded into the result register and presented one per cycle while ready.
// Throughput: one sample per cycle while each sample yields at most one event
//   and the output is ready; extra events hold the result register until taken.
// Reset (synchronous, active low): gesture idle, anchor and hold count zero,
//   registers back to their defaults, no event pending.
// ----------------------------------------------------------------------------
// touch_gesture_to_mouse_events_top
// Turns touch samples into pointer moves, clicks, drags, scroll button pulses
// and macro band selections.
// ----------------------------------------------------------------------------
module touch_gesture_to_mouse_events_top #(
    parameter int COORD_BITS = tgm_pkg::COORD_BITS_DEF,
    parameter int MAX_BANDS  = tgm_pkg::MAX_BANDS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tgm_touch_if.sink    i_touch,
    tgm_cfg_if.sink      i_cfg,
    tgm_event_if.source  o_event
);

    tgm_pkg::t_cfg                cfg;
    tgm_pkg::t_batch              batch;
    logic                         load;
    logic                         free;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;

    tgm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    tgm_decide #(
        .COORD_BITS (COORD_BITS),
        .MAX_BANDS  (MAX_BANDS)
    ) u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_touch (i_touch),
        .i_cfg   (cfg),
        .i_free  (free),
        .o_load  (load),
        .o_batch (batch),
        .o_pos_x (pos_x),
        .o_pos_y (pos_y)
    );

    tgm_evt_out #(
        .COORD_BITS (COORD_BITS)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_batch (batch),
        .i_pos_x (pos_x),
        .i_pos_y (pos_y),
        .o_free  (free),
        .o_event (o_event)
    );

    // Only move events carry a position
    a_pos_only_on_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_event.valid && (o_event.event_kind != tgm_pkg::EV_MOVE)
            |-> (o_event.pos_x == '0) && (o_event.pos_y == '0))
        else $error("position on a non-move event");

    // A macro selection is always the sole event of its sample
    a_macro_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_event.valid && (o_event.event_kind == tgm_pkg::EV_MACRO) |-> o_event.last)
        else $error("macro event not last");

    // A press is always followed by another event of the same sample
    a_press_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_event.valid && (o_event.event_kind == tgm_pkg::EV_PRESS) |-> !o_event.last)
        else $error("press event marked last");

    // A batch is only loaded when the result register has room
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> free)
        else $error("batch loaded over pending events");

endmodule
